// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL files.
// Both use i_clk and i_rst_n of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rsb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsb_pkg
// Types, action codes and constants of the rANS symbol encoder with bypass.
// ----------------------------------------------------------------------------
package rsb_pkg;

    localparam int NUM_ROWS_DEF    = 64;
    localparam int MAX_CDF_LEN_DEF = 64;
    localparam int SCALE_BITS_DEF  = 16;
    localparam int BYPASS_BITS_DEF = 2;

    localparam logic [31:0] LOWER_BOUND = 32'd8388608;
    localparam int          MAX_OUT     = 9;
    localparam int          RAW_W       = 10;

    localparam logic [2:0] ACT_START  = 3'd0;
    localparam logic [2:0] ACT_ROW    = 3'd1;
    localparam logic [2:0] ACT_ENTRY  = 3'd2;
    localparam logic [2:0] ACT_ENCODE = 3'd3;
    localparam logic [2:0] ACT_FLUSH  = 3'd4;

    typedef struct packed {
        logic [2:0]         action;
        logic [5:0]         row;
        logic [5:0]         column;
        logic [6:0]         row_length;
        logic signed [7:0]  row_offset;
        logic [15:0]        entry_start;
        logic [15:0]        entry_range;
        logic signed [7:0]  symbol_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_item;

endpackage

// ----- rtl/rsb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/rans_symbol_encoder_bypass.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rans_symbol_encoder_bypass
// Byte-wise rANS encoder with escape symbols sent as bypass digits.
// ----------------------------------------------------------------------------
// The input channel carries one command item at a time: start, row load,
// entry load, encode or flush. Row and entry tables live in two RAMs that are
// written in the cycle the load item is accepted, so loads, start and unused
// actions keep the input ready. An encode reads the row RAM, works out the
// escape digits, feeds each digit through the bypass renormalization, reads
// the entry RAM and performs the rANS put. The put divides by the symbol
// range with a restoring divider that retires one quotient bit per cycle,
// 31 - SCALE_BITS bits in all. An escape first splits the digit count into
// full groups and a remainder. A flush emits the four state bytes, MSB first.
// Every byte is held back one step so that the last byte of an item can be
// marked; the output register decouples the receiver, and when the receiver
// stalls the engine simply waits before the next byte. Reset returns the
// coder state to 2^23 and empties the output; the tables stay undefined.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rans_symbol_encoder_bypass #(
    parameter int NUM_ROWS    = rsb_pkg::NUM_ROWS_DEF,
    parameter int MAX_CDF_LEN = rsb_pkg::MAX_CDF_LEN_DEF,
    parameter int SCALE_BITS  = rsb_pkg::SCALE_BITS_DEF,
    parameter int BYPASS_BITS = rsb_pkg::BYPASS_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rsb_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rsb_pkg::t_out_item o_out_item
);

    localparam int ROW_AW  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int ENT_D   = NUM_ROWS * MAX_CDF_LEN;
    localparam int ENT_AW  = $clog2(ENT_D);
    localparam int K       = 31 - SCALE_BITS;          // quotient bits of the put
    localparam int B       = BYPASS_BITS;
    localparam int MAXD    = (rsb_pkg::RAW_W + B - 1) / B;
    localparam int DW      = MAXD * B;
    localparam int BMAX    = (1 << B) - 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDROW = 4'd1;
    localparam logic [3:0] S_CALC  = 4'd2;
    localparam logic [3:0] S_GRP   = 4'd3;
    localparam logic [3:0] S_PBSEL = 4'd4;
    localparam logic [3:0] S_PBRN  = 4'd5;
    localparam logic [3:0] S_RDENT = 4'd6;
    localparam logic [3:0] S_SYM   = 4'd7;
    localparam logic [3:0] S_SYMRN = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_FLUSH = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    // Control state.
    logic [3:0]  r_fsm, n_fsm;
    logic [31:0] r_coder, n_coder;
    logic        r_out_vld, n_out_vld;
    logic        r_pend_vld, n_pend_vld;
    logic [3:0]  r_emit_cnt, n_emit_cnt;
    // Working registers.
    rsb_pkg::t_out_item r_out, n_out;
    logic [7:0]        r_pend, n_pend;
    logic [5:0]        r_row, n_row;
    logic signed [7:0] r_sym, n_sym;
    logic [7:0]        r_idx, n_idx;
    logic [DW-1:0]     r_raw, n_raw;
    logic [4:0]        r_dig, n_dig;
    logic [4:0]        r_rest, n_rest;
    logic [4:0]        r_groups, n_groups;
    logic              r_rest_todo, n_rest_todo;
    logic [B-1:0]      r_digit, n_digit;
    logic [15:0]       r_start, n_start;
    logic [15:0]       r_range, n_range;
    logic [15:0]       r_rem, n_rem;
    logic [K-1:0]      r_dvd, n_dvd;
    logic [4:0]        r_cnt, n_cnt;

    // RAM ports.
    logic              row_we, ent_we, row_re, ent_re;
    logic [ROW_AW-1:0] row_waddr, row_raddr;
    logic [ENT_AW-1:0] ent_waddr, ent_raddr;
    logic [14:0]       row_rdata;
    logic [31:0]       ent_rdata;

    logic in_acc, can_push, row_ok, col_ok;

    assign in_acc   = i_in_valid && o_in_ready;
    assign can_push = !r_out_vld || i_out_ready;
    assign row_ok   = 9'(i_in_item.row) < 9'(NUM_ROWS);
    assign col_ok   = 9'(i_in_item.column) < 9'(MAX_CDF_LEN);

    assign row_we    = in_acc && i_in_item.action == rsb_pkg::ACT_ROW && row_ok;
    assign row_waddr = ROW_AW'(i_in_item.row);
    assign ent_we    = in_acc && i_in_item.action == rsb_pkg::ACT_ENTRY && row_ok && col_ok;
    assign ent_waddr = ENT_AW'(ENT_AW'(i_in_item.row) * ENT_AW'(MAX_CDF_LEN)
                       + ENT_AW'(i_in_item.column));
    assign row_re    = r_fsm == S_RDROW;
    assign row_raddr = ROW_AW'(r_row);
    assign ent_re    = r_fsm == S_RDENT;
    assign ent_raddr = ENT_AW'(ENT_AW'(r_row) * ENT_AW'(MAX_CDF_LEN) + ENT_AW'(r_idx));

    rsb_ram #(.WIDTH(15), .DEPTH(NUM_ROWS), .AW(ROW_AW)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata ({i_in_item.row_length, i_in_item.row_offset}),
        .i_re    (row_re),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    rsb_ram #(.WIDTH(32), .DEPTH(ENT_D), .AW(ENT_AW)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata ({i_in_item.entry_range, i_in_item.entry_start}),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    // Symbol classification from the row read.
    logic [8:0]         len_c, top;
    logic signed [9:0]  value;
    logic               esc;
    logic [rsb_pkg::RAW_W-1:0] raw;
    logic [4:0]         dcount;

    always_comb begin
        len_c = 9'(row_rdata[14:8]);
        if (len_c < 9'd2) begin
            len_c = 9'd2;
        end else if (len_c > 9'(MAX_CDF_LEN)) begin
            len_c = 9'(MAX_CDF_LEN);
        end
        top   = len_c - 9'd2;
        value = 10'(r_sym) - 10'($signed(row_rdata[7:0]));
        esc   = value < 0 || value >= $signed({1'b0, top});
        if (value < 0) begin
            raw = rsb_pkg::RAW_W'(-(value <<< 1) - 10'sd1);
        end else begin
            raw = rsb_pkg::RAW_W'((value - $signed({1'b0, top})) <<< 1);
        end
        dcount = '0;
        for (int i = 0; i < MAXD; i++) begin
            dcount = dcount + 5'((raw >> (i * B)) != '0);
        end
    end

    // Byte emission: each new byte pushes the previous pending one out.
    logic       emit_req, emit_go, drop;
    logic [7:0] emit_byte;
    logic       bp_big;
    logic [47:0] sym_lim;
    logic [16:0] trial;

    assign drop    = r_emit_cnt >= 4'(rsb_pkg::MAX_OUT);
    assign bp_big  = r_coder >= (32'd1 << (31 - B));
    assign sym_lim = 48'(r_range) << K;
    assign trial   = {r_rem, r_dvd[K-1]};

    always_comb begin
        emit_req  = 1'b0;
        emit_byte = r_coder[7:0];
        unique case (r_fsm)
            S_PBRN:  emit_req = bp_big;
            S_SYMRN: emit_req = 48'(r_coder) >= sym_lim;
            S_FLUSH: begin
                emit_req  = 1'b1;
                emit_byte = r_coder[r_cnt[1:0]*8 +: 8];
            end
            default: emit_req = 1'b0;
        endcase
        emit_go = emit_req && (drop || !r_pend_vld || can_push);
    end

    always_comb begin
        n_fsm = r_fsm;  n_coder = r_coder;  n_out_vld = r_out_vld;
        n_pend_vld = r_pend_vld;  n_emit_cnt = r_emit_cnt;
        n_out = r_out;  n_pend = r_pend;  n_row = r_row;  n_sym = r_sym;
        n_idx = r_idx;  n_raw = r_raw;  n_dig = r_dig;  n_rest = r_rest;
        n_groups = r_groups;  n_rest_todo = r_rest_todo;  n_digit = r_digit;
        n_start = r_start;  n_range = r_range;  n_rem = r_rem;  n_dvd = r_dvd;
        n_cnt = r_cnt;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if (emit_go && !drop) begin
            if (r_pend_vld) begin
                n_out     = '{out_byte: r_pend, last_byte: 1'b0};
                n_out_vld = 1'b1;
            end
            n_pend     = emit_byte;
            n_pend_vld = 1'b1;
            n_emit_cnt = r_emit_cnt + 4'd1;
        end

        unique case (r_fsm)
            S_IDLE: begin
                if (in_acc) begin
                    n_emit_cnt = '0;
                    n_row      = i_in_item.row;
                    n_sym      = i_in_item.symbol_value;
                    priority if (i_in_item.action == rsb_pkg::ACT_START) begin
                        n_coder = rsb_pkg::LOWER_BOUND;
                    end else if (i_in_item.action == rsb_pkg::ACT_ENCODE && row_ok) begin
                        n_fsm = S_RDROW;
                    end else if (i_in_item.action == rsb_pkg::ACT_FLUSH) begin
                        n_cnt = 5'd3;
                        n_fsm = S_FLUSH;
                    end else begin
                        n_fsm = S_IDLE;
                    end
                end
            end
            S_RDROW: n_fsm = S_CALC;
            S_CALC: begin
                n_idx       = esc ? top[7:0] : value[7:0];
                n_raw       = DW'(raw);
                n_dig       = dcount;
                n_rest      = dcount;
                n_groups    = '0;
                n_rest_todo = 1'b1;
                n_fsm       = esc ? S_GRP : S_RDENT;
            end
            S_GRP: begin
                // Split the digit count into full groups and a remainder.
                if (9'(r_rest) >= 9'(BMAX)) begin
                    n_rest   = 5'(9'(r_rest) - 9'(BMAX));
                    n_groups = r_groups + 5'd1;
                end else begin
                    n_fsm = S_PBSEL;
                end
            end
            S_PBSEL: begin
                // Digits go out last-stored first: raw digits from the top,
                // then the remainder, then the full groups.
                priority if (r_dig != '0) begin
                    n_digit = r_raw[(r_dig - 5'd1) * B +: B];
                    n_dig   = r_dig - 5'd1;
                    n_fsm   = S_PBRN;
                end else if (r_rest_todo) begin
                    n_digit     = B'(r_rest);
                    n_rest_todo = 1'b0;
                    n_fsm       = S_PBRN;
                end else if (r_groups != '0) begin
                    n_digit  = B'(BMAX);
                    n_groups = r_groups - 5'd1;
                    n_fsm    = S_PBRN;
                end else begin
                    n_fsm = S_RDENT;
                end
            end
            S_PBRN: begin
                if (emit_req) begin
                    if (emit_go) begin
                        n_coder = r_coder >> 8;
                    end
                end else begin
                    n_coder = 32'(r_coder << B) | 32'(r_digit);
                    n_fsm   = S_PBSEL;
                end
            end
            S_RDENT: n_fsm = S_SYM;
            S_SYM: begin
                n_start = ent_rdata[15:0];
                n_range = (ent_rdata[31:16] == '0) ? 16'd1 : ent_rdata[31:16];
                n_fsm   = S_SYMRN;
            end
            S_SYMRN: begin
                if (emit_req) begin
                    if (emit_go) begin
                        n_coder = r_coder >> 8;
                    end
                end else begin
                    // State is below range << K, so the top part is below range.
                    n_rem = 16'(r_coder >> K);
                    n_dvd = r_coder[K-1:0];
                    n_cnt = 5'(K);
                    n_fsm = S_DIV;
                end
            end
            S_DIV: begin
                if (trial >= {1'b0, r_range}) begin
                    n_rem = 16'(trial - {1'b0, r_range});
                    n_dvd = {r_dvd[K-2:0], 1'b1};
                end else begin
                    n_rem = trial[15:0];
                    n_dvd = {r_dvd[K-2:0], 1'b0};
                end
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    n_fsm = S_FIN;
                end
            end
            S_FIN: begin
                n_coder = 32'(32'(r_dvd) << SCALE_BITS) + 32'(r_rem) + 32'(r_start);
                n_fsm   = S_DONE;
            end
            S_FLUSH: begin
                if (emit_go) begin
                    n_cnt = r_cnt - 5'd1;
                    if (r_cnt == '0) begin
                        n_fsm = S_DONE;
                    end
                end
            end
            S_DONE: begin
                // Release the held byte marked as the last one of the item.
                if (!r_pend_vld) begin
                    n_fsm = S_IDLE;
                end else if (can_push) begin
                    n_out      = '{out_byte: r_pend, last_byte: 1'b1};
                    n_out_vld  = 1'b1;
                    n_pend_vld = 1'b0;
                    n_fsm      = S_IDLE;
                end
            end
            default: n_fsm = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm      <= S_IDLE;
            r_coder    <= rsb_pkg::LOWER_BOUND;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_emit_cnt <= '0;
        end else begin
            r_fsm      <= n_fsm;
            r_coder    <= n_coder;
            r_out_vld  <= n_out_vld;
            r_pend_vld <= n_pend_vld;
            r_emit_cnt <= n_emit_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out       <= n_out;
        r_pend      <= n_pend;
        r_row       <= n_row;
        r_sym       <= n_sym;
        r_idx       <= n_idx;
        r_raw       <= n_raw;
        r_dig       <= n_dig;
        r_rest      <= n_rest;
        r_groups    <= n_groups;
        r_rest_todo <= n_rest_todo;
        r_digit     <= n_digit;
        r_start     <= n_start;
        r_range     <= n_range;
        r_rem       <= n_rem;
        r_dvd       <= n_dvd;
        r_cnt       <= n_cnt;
    end

    assign o_in_ready  = r_fsm == S_IDLE;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    `ASSERT_ALWAYS(a_emit_cap, r_emit_cnt <= 4'(rsb_pkg::MAX_OUT), "byte count overrun")
    `ASSERT_ALWAYS(a_idle_empty, r_fsm != S_IDLE || !r_pend_vld, "held byte left at idle")
    `ASSERT_ALWAYS(a_div_rem, r_fsm != S_DIV || r_rem < r_range, "divider remainder too big")
    `ASSERT_NEXT(a_fin_done, r_fsm == S_FIN, r_fsm == S_DONE, "put did not finish")

endmodule

// ----- sim/rans_stream_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rans_stream_checker
// Watches both channels of the rANS encoder, predicts its bytes and compares.
// ----------------------------------------------------------------------------
module rans_stream_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  rsb_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  rsb_pkg::t_out_item i_out_item,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_checked
);

    logic [31:0]        coder_state;
    logic [6:0]         row_len_mem [64];
    logic signed [7:0]  row_off_mem [64];
    logic [31:0]        entry_mem [4096];
    logic [7:0]         step_bytes [$];
    rsb_pkg::t_out_item expected_bytes [$];

    task automatic emit_byte(input logic [7:0] b);
        if (step_bytes.size() < rsb_pkg::MAX_OUT) begin
            step_bytes.insert(step_bytes.size(), b);
        end
    endtask

    // Bypass digit: renormalize so the shifted state stays below 2^32.
    task automatic put_digit(input logic [1:0] d);
        while (coder_state >= 32'h2000_0000) begin
            emit_byte(coder_state[7:0]);
            coder_state = coder_state >> 8;
        end
        coder_state = {coder_state[29:0], d};
    endtask

    task automatic put_symbol(input logic [15:0] start, input logic [31:0] freq);
        longint unsigned bound;
        logic [31:0]     quot;
        logic [31:0]     remd;
        bound = 64'd32768 * freq;
        while (64'(coder_state) >= bound) begin
            emit_byte(coder_state[7:0]);
            coder_state = coder_state >> 8;
        end
        quot = coder_state / freq;
        remd = coder_state % freq;
        coder_state = (quot << 16) + remd + 32'(start);
    endtask

    task automatic encode_symbol(input logic [5:0] row, input logic signed [7:0] sym);
        int          len;
        int          top;
        int          value;
        int unsigned raw;
        int          count;
        int          rest;
        int          n;
        int          digits [64];
        logic [31:0] entry;
        logic [31:0] freq;
        len = int'(row_len_mem[row]);
        if (len < 2) len = 2;
        if (len > 64) len = 64;
        top = len - 2;
        value = int'(sym) - int'(row_off_mem[row]);
        if (value < 0 || value >= top) begin
            // Escape: zigzag magnitude, then length groups and digits in reverse.
            raw = (value < 0) ? unsigned'(-2 * value - 1) : unsigned'(2 * (value - top));
            count = 0;
            while (count * 2 < 32 && (raw >> (count * 2)) != 0) count++;
            n = 0;
            rest = count;
            while (rest >= 3 && n < 63) begin
                digits[n] = 3;
                n++;
                rest -= 3;
            end
            digits[n] = rest;
            n++;
            for (int i = 0; i < count && n < 64; i++) begin
                digits[n] = (raw >> (i * 2)) & 3;
                n++;
            end
            for (int i = n - 1; i >= 0; i--) put_digit(2'(digits[i]));
            value = top;
        end
        entry = entry_mem[row * 64 + value];
        freq = {16'd0, entry[31:16]};
        if (freq == 0) freq = 1;
        put_symbol(entry[15:0], freq);
    endtask

    task automatic predict_command(input rsb_pkg::t_in_item it);
        rsb_pkg::t_out_item res;
        step_bytes.delete();
        case (it.action)
            rsb_pkg::ACT_START:  coder_state = rsb_pkg::LOWER_BOUND;
            rsb_pkg::ACT_ROW: begin
                row_len_mem[it.row] = it.row_length;
                row_off_mem[it.row] = it.row_offset;
            end
            rsb_pkg::ACT_ENTRY:
                entry_mem[it.row * 64 + it.column] = {it.entry_range, it.entry_start};
            rsb_pkg::ACT_ENCODE: encode_symbol(it.row, it.symbol_value);
            rsb_pkg::ACT_FLUSH: begin
                emit_byte(coder_state[31:24]);
                emit_byte(coder_state[23:16]);
                emit_byte(coder_state[15:8]);
                emit_byte(coder_state[7:0]);
            end
            default: ;
        endcase
        foreach (step_bytes[i]) begin
            res.out_byte  = step_bytes[i];
            res.last_byte = (i == step_bytes.size() - 1);
            expected_bytes.insert(expected_bytes.size(), res);
        end
    endtask

    always @(posedge i_clk) begin
        rsb_pkg::t_out_item want;
        if (!i_rst_n) begin
            coder_state = rsb_pkg::LOWER_BOUND;
            expected_bytes.delete();
            o_errors  = 0;
            o_checked = 0;
        end else begin
            if (i_in_valid && i_in_ready) predict_command(i_in_item);
            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (expected_bytes.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: unexpected byte %02h last %0b", $realtime,
                                 i_out_item.out_byte, i_out_item.last_byte);
                end else begin
                    want = expected_bytes.pop_front();
                    if (want.out_byte !== i_out_item.out_byte ||
                        want.last_byte !== i_out_item.last_byte) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%0t: byte mismatch, expected %02h last %0b, got %02h last %0b",
                                     $realtime, want.out_byte, want.last_byte,
                                     i_out_item.out_byte, i_out_item.last_byte);
                    end
                end
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

// ----- sim/tb_rans_symbol_encoder_bypass.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rans_symbol_encoder_bypass
// Command stimulus and verdict for the rANS encoder with bypass coding.
// ----------------------------------------------------------------------------
// Rows are always set up as a whole (row load followed by every entry the
// encoder can reach), so no encode ever touches an unwritten table entry. The
// checker beside the block predicts every stream byte and compares.
// ----------------------------------------------------------------------------
module tb_rans_symbol_encoder_bypass;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 350;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    rsb_pkg::t_in_item  in_item = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    rsb_pkg::t_out_item out_item;

    int        error_count;
    int        pending_count;
    int        checked_count;

    // Once set, neither side starts new random idle periods.
    bit        quiet_phase = 1'b0;
    int        sent_items = 0;
    int        sent_encodes = 0;
    int        sent_flushes = 0;
    bit        row_ready [64];
    int        ready_rows [$];
    int        stall_left = 0;
    int        idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rans_symbol_encoder_bypass i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    rans_stream_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_errors    (error_count),
        .o_pending   (pending_count),
        .o_checked   (checked_count)
    );

    // The receiver stalls in random bursts until the quiet phase begins.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 99) < 12) begin
            stall_left <= $urandom_range(0, 11);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[rans_symbol_encoder_bypass] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Unused fields carry random content so every bit gets toggled.
    function automatic rsb_pkg::t_in_item random_item(input logic [2:0] act);
        rsb_pkg::t_in_item it;
        it = rsb_pkg::t_in_item'({$urandom, $urandom, $urandom});
        it.action = act;
        return it;
    endfunction

    task automatic send_item(input rsb_pkg::t_in_item it);
        in_item <= it;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        if (it.action <= rsb_pkg::ACT_FLUSH) sent_items++;
        if (it.action == rsb_pkg::ACT_ENCODE) sent_encodes++;
        if (it.action == rsb_pkg::ACT_FLUSH) sent_flushes++;
        if (!quiet_phase && $urandom_range(0, 99) < 15) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] pick_range();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 16'd0;
        if (sel == 1) return 16'hffff;
        if (sel < 8) return 16'($urandom_range(1, 255));
        return 16'($urandom);
    endfunction

    // A row load plus every entry an encode on that row can read.
    task automatic setup_row(input int row, input logic [6:0] len_raw,
                             input logic signed [7:0] offset);
        rsb_pkg::t_in_item it;
        int                eff;
        it = random_item(rsb_pkg::ACT_ROW);
        it.row = 6'(row);
        it.row_length = len_raw;
        it.row_offset = offset;
        send_item(it);
        eff = (len_raw < 2) ? 2 : (len_raw > 64) ? 64 : int'(len_raw);
        for (int c = 0; c <= eff - 2; c++) begin
            it = random_item(rsb_pkg::ACT_ENTRY);
            it.row = 6'(row);
            it.column = 6'(c);
            it.entry_range = pick_range();
            if (c == 0 && $urandom_range(0, 3) == 0) it.entry_start = 16'hffff;
            send_item(it);
        end
        if (!row_ready[row]) ready_rows.insert(ready_rows.size(), row);
        row_ready[row] = 1'b1;
    endtask

    task automatic encode_on(input int row, input logic signed [7:0] sym);
        rsb_pkg::t_in_item it;
        it = random_item(rsb_pkg::ACT_ENCODE);
        it.row = 6'(row);
        it.symbol_value = sym;
        send_item(it);
    endtask

    initial begin
        rsb_pkg::t_in_item it;
        int                sel;
        int                row;
        bit                big_done;
        bit                paused;
        big_done = 1'b0;
        paused = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: flush of the reset state, shortest and clamped rows,
        // symbol extremes, restart and an unused action.
        send_item(random_item(rsb_pkg::ACT_FLUSH));
        setup_row(0, 7'd0, 8'sd0);
        encode_on(0, -8'sd128);
        encode_on(0, 8'sd127);
        encode_on(0, 8'sd0);
        setup_row(1, 7'd5, -8'sd128);
        encode_on(1, 8'sd127);
        encode_on(1, -8'sd128);
        encode_on(1, -8'sd126);
        encode_on(1, -8'sd125);
        send_item(random_item(rsb_pkg::ACT_FLUSH));
        send_item(random_item(rsb_pkg::ACT_START));
        encode_on(1, 8'sd0);
        send_item(random_item(3'd7));
        send_item(random_item(rsb_pkg::ACT_FLUSH));

        // Random part: mostly encodes on fully set-up rows, with flushes,
        // restarts, table rewrites and ignored actions mixed in.
        while (sent_items < RANDOM_ITEMS) begin
            if (sent_items > 290) quiet_phase = 1'b1;
            if (!paused && sent_items > 150) begin
                // Let the block drain completely before going on.
                paused = 1'b1;
                in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_count != 0) @(posedge i_clk);
            end
            sel = $urandom_range(0, 99);
            row = ready_rows[$urandom_range(0, ready_rows.size() - 1)];
            if (!big_done && sent_items > 100) begin
                big_done = 1'b1;
                setup_row($urandom_range(2, 63), 7'd127, 8'($urandom));
            end else if (ready_rows.size() < 4 || sel < 7) begin
                setup_row($urandom_range(0, 63), 7'($urandom_range(0, 9)), 8'($urandom));
            end else if (sel < 70) begin
                encode_on(row, 8'($urandom));
            end else if (sel < 80) begin
                send_item(random_item(rsb_pkg::ACT_FLUSH));
            end else if (sel < 85) begin
                send_item(random_item(rsb_pkg::ACT_START));
            end else if (sel < 95) begin
                it = random_item(rsb_pkg::ACT_ENTRY);
                it.row = 6'(row);
                it.entry_range = pick_range();
                send_item(it);
            end else begin
                send_item(random_item(3'($urandom_range(5, 7))));
            end
        end
        in_valid <= 1'b0;
        @(posedge i_clk);

        while (pending_count != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Sent %0d commands (%0d encodes, %0d flushes); checked %0d stream bytes.",
                 sent_items, sent_encodes, sent_flushes, checked_count);
        if (error_count == 0 && pending_count == 0) begin
            $display("[rans_symbol_encoder_bypass] OK");
        end else begin
            $display("[rans_symbol_encoder_bypass] ERROR");
        end
        $finish;
    end

endmodule

// ----- rans_symbol_encoder_bypass.f -----
+incdir+rtl
rtl/rsb_pkg.sv
rtl/rsb_ram.sv
rtl/rans_symbol_encoder_bypass.sv
sim/rans_stream_checker.sv
sim/tb_rans_symbol_encoder_bypass.sv
